@@ rtl/bsf_pkg.sv @@
// Shared types and constants for the byte-stuffing framer with CRC-8 trailer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bsf_pkg;

  // Configuration register indexes
  localparam logic [7:0] RegFlag   = 8'd0;
  localparam logic [7:0] RegEscape = 8'd1;
  localparam logic [7:0] RegPoly   = 8'd2;
  localparam logic [7:0] RegStart  = 8'd3;

  // Reset values of the configuration registers
  localparam logic [7:0] FlagRst   = 8'h24;
  localparam logic [7:0] EscapeRst = 8'h2F;
  localparam logic [7:0] PolyRst   = 8'h07;
  localparam logic [7:0] StartRst  = 8'hFF;

  // Output byte kinds
  localparam logic [1:0] KindFlag = 2'd0;
  localparam logic [1:0] KindEsc  = 2'd1;
  localparam logic [1:0] KindData = 2'd2;
  localparam logic [1:0] KindCrc  = 2'd3;

  // Default depth of the command queue between front and back end
  localparam int unsigned CmdDepth = 4;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] poly;
    logic [7:0] start;
  } cfg_t;

  // One classified payload byte
  typedef struct packed {
    logic [7:0] data;
    logic       open;  // frame opens before this byte
    logic       esc;   // byte needs an escape
    logic       last;  // frame closes after this byte
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/bsf_front.sv @@
// Front end: accepts payload bytes and classifies them into commands.
// Depends on bsf_pkg.
`default_nettype none

module bsf_front
  import bsf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire cfg_t       cfg_i,
  input  wire logic       cmd_full_i,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o
);

  logic open_q, open_d;
  logic accept;

  assign accept      = push_i && !cmd_full_i;
  assign cmd_valid_o = push_i;

  always_comb begin
    cmd_o.data = data_byte_i;
    cmd_o.open = !open_q;
    cmd_o.esc  = (data_byte_i == cfg_i.flag) || (data_byte_i == cfg_i.escape);
    cmd_o.last = last_byte_i;
  end

  // tracks whether a frame is open as seen by accepted items
  always_comb begin
    open_d = open_q;
    if (accept) begin
      open_d = !last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsf_cmd_fifo.sv @@
// Short command queue between front end and back end.
// Depends on bsf_pkg.
`default_nettype none

module bsf_cmd_fifo
  import bsf_pkg::*;
#(
  parameter int unsigned Depth = CmdDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  input  wire cmd_t wr_data_i,
  output logic      full_o,
  output cmd_t      rd_data_o,
  output logic      empty_o,
  input  wire logic rd_pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          we, re;

  assign full_o    = (cnt_q == CW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign we        = wr_valid_i && !full_o;
  assign re        = rd_pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (we) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (re) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({we, re})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bsf_back.sv @@
// Back end: expands each command into line bytes, keeps the running CRC-8
// and holds the result register. Depends on bsf_pkg.
`default_nettype none

module bsf_back
  import bsf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire cmd_t       cmd_i,
  input  wire logic       cmd_empty_i,
  output logic            cmd_pop_o,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic            run_last_o
);

  typedef enum logic [4:0] {
    PhOpen  = 5'b00001,
    PhEsc   = 5'b00010,
    PhData  = 5'b00100,
    PhClose = 5'b01000,
    PhCrc   = 5'b10000
  } phase_e;

  function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] b,
                                          logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  phase_e     phase_q, phase_d;
  phase_e     cur, nxt;
  logic       mid_q, mid_d;
  logic       done;
  logic       advance;
  logic [7:0] crc_q, crc_d;
  logic [7:0] byte_c;
  logic [1:0] kind_c;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic [1:0] out_kind_q;
  logic       out_last_q;

  assign advance    = !cmd_empty_i && (!out_valid_q || pop);
  assign cmd_pop_o  = advance && done;
  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_kind_o = out_kind_q;
  assign run_last_o = out_last_q;

  // phase of the byte to emit for the head command
  always_comb begin
    if (mid_q) begin
      cur = phase_q;
    end else if (cmd_i.open) begin
      cur = PhOpen;
    end else if (cmd_i.esc) begin
      cur = PhEsc;
    end else begin
      cur = PhData;
    end
  end

  always_comb begin
    nxt    = PhData;
    done   = 1'b0;
    byte_c = cmd_i.data;
    kind_c = KindData;
    case (cur)
      PhOpen: begin
        byte_c = cfg_i.flag;
        kind_c = KindFlag;
        nxt    = cmd_i.esc ? PhEsc : PhData;
      end
      PhEsc: begin
        byte_c = cfg_i.escape;
        kind_c = KindEsc;
        nxt    = PhData;
      end
      PhData: begin
        byte_c = cmd_i.data;
        kind_c = KindData;
        nxt    = PhClose;
        done   = !cmd_i.last;
      end
      PhClose: begin
        byte_c = cfg_i.flag;
        kind_c = KindFlag;
        nxt    = PhCrc;
      end
      PhCrc: begin
        byte_c = crc_q;
        kind_c = KindCrc;
        done   = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    mid_d       = mid_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !pop;
    if (advance) begin
      out_valid_d = 1'b1;
      mid_d       = !done;
      phase_d     = nxt;
      case (cur)
        PhOpen:  crc_d = crc_fold(cfg_i.start, byte_c, cfg_i.poly);
        PhCrc:   crc_d = crc_q;  // trailer is not folded in
        default: crc_d = crc_fold(crc_q, byte_c, cfg_i.poly);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhOpen;
      mid_q       <= 1'b0;
      crc_q       <= StartRst;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mid_q       <= mid_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_c;
      out_kind_q <= kind_c;
      out_last_q <= done;
    end
  end

endmodule

`default_nettype wire

@@ rtl/byte_stuff_framer_crc8_top.sv @@
// Byte-stuffing transmit framer with CRC-8 trailer. Payload bytes enter on
// the push side; each item yields one to five line bytes (opening flag,
// escape, data, closing flag, CRC trailer) that leave on the pop side one
// byte per cycle while pop is held. An item is taken every cycle while the
// command queue (CmdQueueDepth entries) has room; the sustained rate is set
// by the back end, which keeps an item until all its line bytes (one for a
// plain byte inside a frame, up to five) are out. Configuration writes
// always complete at once and are to be made only while idle.
// Depends on bsf_pkg, bsf_front, bsf_cmd_fifo and bsf_back.
`default_nettype none

module byte_stuff_framer_crc8_top
  import bsf_pkg::*;
#(
  parameter int unsigned CmdQueueDepth = CmdDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic            run_last_o
);

  cfg_t cfg_q, cfg_d;
  cmd_t cmd_wr, cmd_rd;
  logic cmd_wr_valid, cmd_empty, cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFlag:   cfg_d.flag   = cfg_data_i;
        RegEscape: cfg_d.escape = cfg_data_i;
        RegPoly:   cfg_d.poly   = cfg_data_i;
        RegStart:  cfg_d.start  = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag   <= FlagRst;
      cfg_q.escape <= EscapeRst;
      cfg_q.poly   <= PolyRst;
      cfg_q.start  <= StartRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_i       (cfg_q),
    .cmd_full_i  (full),
    .cmd_valid_o (cmd_wr_valid),
    .cmd_o       (cmd_wr)
  );

  bsf_cmd_fifo #(
    .Depth (CmdQueueDepth)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_wr_valid),
    .wr_data_i  (cmd_wr),
    .full_o     (full),
    .rd_data_o  (cmd_rd),
    .empty_o    (cmd_empty),
    .rd_pop_i   (cmd_pop)
  );

  bsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_rd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire
